@@ hw/rtl/slum_pkg.sv @@
package slum_pkg;

	typedef enum logic [1:0] {
		ACT_LOAD_A = 2'd0,
		ACT_LOAD_B = 2'd1,
		ACT_MERGE  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_WALK = 1'b1
	} state_t;

	localparam int unsigned ELEM_W = 32;

endpackage

@@ hw/rtl/slum_list_ram.sv @@
module slum_list_ram #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned WIDTH = 32,
	parameter int unsigned AW    = 5
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/sorted_list_union_merge.sv @@
// Channel   Direction  Signals                          Accepted when
// command   in         start, action, value             start && !busy
// result    out        result_strobe, element, last,    every cycle result_strobe is high
//                      dropped
//
// A merge holds busy high while it walks both lists, one list
// element per cycle through the registered read ports of the two list memories.
// Results come at most one per cycle; duplicates leave gaps in the strobe.
// Reset clears the counts, the overflow flag and the walk state; list contents persist.
// The receiver cannot stall: each result is on the ports for one cycle only.
module sorted_list_union_merge #(
	parameter int unsigned LIST_DEPTH = 32,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         action,
	input  logic signed [31:0] value,
	output logic               result_strobe,
	output logic signed [31:0] element,
	output logic               last,
	output logic               dropped
);

	localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
	localparam int unsigned XW = (DATA_WIDTH > slum_pkg::ELEM_W) ? DATA_WIDTH : slum_pkg::ELEM_W;
	localparam logic [CW-1:0] FULL = CW'(LIST_DEPTH);

	slum_pkg::state_t state_q, state_d;

	logic [CW-1:0] count_a_q, count_b_q;
	logic [CW-1:0] ptr_a_q, ptr_b_q, ptr_a_d, ptr_b_d;
	logic          overflow_q;
	logic [DATA_WIDTH-1:0] pend_q, pend_d;
	logic                  have_pend_q, have_pend_d;

	logic                  accept, load_a, load_b, merge;
	logic [DATA_WIDTH-1:0] wr_data;
	logic [AW-1:0]         raddr_a, raddr_b;
	logic [DATA_WIDTH-1:0] head_a, head_b;
	logic                  a_left, b_left, take_a, walk_done, clear;
	logic [DATA_WIDTH-1:0] taken;
	logic [DATA_WIDTH-1:0] emit_val;
	logic                  emit, emit_last;
	logic signed [XW-1:0]  emit_ext;

	assign accept = start && !busy;
	assign load_a = accept && (action == slum_pkg::ACT_LOAD_A) && (count_a_q != FULL);
	assign load_b = accept && (action == slum_pkg::ACT_LOAD_B) && (count_b_q != FULL);
	assign merge  = accept && (action == slum_pkg::ACT_MERGE);
	assign wr_data = DATA_WIDTH'(XW'($unsigned(value)));

	assign raddr_a = (ptr_a_d < FULL) ? ptr_a_d[AW-1:0] : '0;
	assign raddr_b = (ptr_b_d < FULL) ? ptr_b_d[AW-1:0] : '0;

	slum_list_ram #(.DEPTH(LIST_DEPTH), .WIDTH(DATA_WIDTH), .AW(AW)) u_ram_a (
		.clk   (clk),
		.we    (load_a),
		.waddr (count_a_q[AW-1:0]),
		.wdata (wr_data),
		.raddr (raddr_a),
		.rdata (head_a)
	);

	slum_list_ram #(.DEPTH(LIST_DEPTH), .WIDTH(DATA_WIDTH), .AW(AW)) u_ram_b (
		.clk   (clk),
		.we    (load_b),
		.waddr (count_b_q[AW-1:0]),
		.wdata (wr_data),
		.raddr (raddr_b),
		.rdata (head_b)
	);

	assign a_left    = ptr_a_q < count_a_q;
	assign b_left    = ptr_b_q < count_b_q;
	assign walk_done = !a_left && !b_left;
	assign take_a    = a_left && (!b_left || ($signed(head_a) <= $signed(head_b)));
	assign taken     = take_a ? head_a : head_b;

	always_comb begin
		state_d     = state_q;
		ptr_a_d     = '0;
		ptr_b_d     = '0;
		pend_d      = pend_q;
		have_pend_d = have_pend_q;
		emit        = 1'b0;
		emit_last   = 1'b0;
		emit_val    = pend_q;
		clear       = 1'b0;
		case (state_q)
			slum_pkg::ST_IDLE: begin
				if (merge) begin
					state_d     = slum_pkg::ST_WALK;
					have_pend_d = 1'b0;
				end
			end
			slum_pkg::ST_WALK: begin
				ptr_a_d = ptr_a_q;
				ptr_b_d = ptr_b_q;
				if (walk_done) begin
					emit      = have_pend_q;
					emit_last = 1'b1;
					clear     = 1'b1;
					state_d   = slum_pkg::ST_IDLE;
					ptr_a_d   = '0;
					ptr_b_d   = '0;
				end else begin
					if (take_a) begin
						ptr_a_d = ptr_a_q + CW'(1);
					end else begin
						ptr_b_d = ptr_b_q + CW'(1);
					end
					if (!have_pend_q) begin
						pend_d      = taken;
						have_pend_d = 1'b1;
					end else if (taken != pend_q) begin
						emit   = 1'b1;
						pend_d = taken;
					end
				end
			end
			default: begin
				state_d = slum_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= slum_pkg::ST_IDLE;
			count_a_q   <= '0;
			count_b_q   <= '0;
			ptr_a_q     <= '0;
			ptr_b_q     <= '0;
			overflow_q  <= 1'b0;
			have_pend_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ptr_a_q     <= ptr_a_d;
			ptr_b_q     <= ptr_b_d;
			have_pend_q <= have_pend_d;
			if (clear) begin
				count_a_q  <= '0;
				count_b_q  <= '0;
				overflow_q <= 1'b0;
			end else begin
				if (load_a) begin
					count_a_q <= count_a_q + CW'(1);
				end
				if (load_b) begin
					count_b_q <= count_b_q + CW'(1);
				end
				if (accept && ((action == slum_pkg::ACT_LOAD_A && count_a_q == FULL) ||
						(action == slum_pkg::ACT_LOAD_B && count_b_q == FULL))) begin
					overflow_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_q <= pend_d;
	end

	assign emit_ext      = XW'($signed(emit_val));
	assign busy          = (state_q != slum_pkg::ST_IDLE);
	assign result_strobe = emit;
	assign element       = emit_ext[31:0];
	assign last          = emit_last;
	assign dropped       = overflow_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> busy)
		else $error("result outside a merge");

	assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && last) |=> !busy)
		else $error("merge did not finish after last result");

	assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && $past(result_strobe)) |-> (element != $past(element)))
		else $error("duplicate element emitted");

	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action == slum_pkg::ACT_MERGE) |=> busy)
		else $error("merge transaction not started");

	assert property (@(posedge clk) disable iff (!arst_n)
		(count_a_q <= FULL) && (count_b_q <= FULL))
		else $error("list count beyond capacity");

endmodule
